/* rtl/core/sqrs_pkg.sv */
// Shared types and constants for the square-root simplifier core.
package sqrs_pkg;

   // Widths of the result fields.
   localparam int unsigned COEF_WIDTH = 16;
   localparam int unsigned REM_WIDTH  = 31;

   // Status of the serial divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* rtl/core/sqrs_divider.sv */
// Restoring serial divider that produces one quotient bit per cycle.
module sqrs_divider #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DATA_WIDTH-1:0]     dividend,
   input  logic [DATA_WIDTH-1:0]     divisor,
   output logic [DATA_WIDTH-1:0]     quotient,
   output logic [DATA_WIDTH-1:0]     remainder,
   output sqrs_pkg::div_status_type  status
);
   import sqrs_pkg::*;

   localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;

   // One restoring step: shift in the next dividend bit and try the subtraction.
   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DATA_WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DATA_WIDTH]) begin
            rem_in = diff[DATA_WIDTH-1:0];
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
         end
         quo_in = {quo_ff[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is cleared by reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* rtl/core/square_root_simplifier_core.sv */
// Square-free decomposition core: n = a * a * b for one radicand per request.
//
// Input channel (req_): one signed radicand per request, taken when req_valid is
// high and req_stall is low. The core takes a new request only when its
// sequencer is idle, so req_stall stays high while a request is being worked.
// Result channel (rsp_): coefficient a, square-free remainder b and a flag for
// a negative radicand. The result sits in an output register; a stall on the
// result side holds it there, and the core may meanwhile take and work the next
// request, parking that result until the output register is free.
// A negative or zero radicand skips the search and gives the fixed result. Otherwise
// the integer square root is found bit by bit on the shared multiplier, and each
// candidate divisor tested downwards from it is checked on the serial divider,
// which produces one quotient bit per cycle.
// Reset is synchronous and active high; it drops any request in flight and any
// result not yet taken.
module square_root_simplifier_core #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [DATA_WIDTH-1:0]       req_radicand,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sqrs_pkg::COEF_WIDTH-1:0]    rsp_coefficient,
   output logic [sqrs_pkg::REM_WIDTH-1:0]     rsp_remainder,
   output logic                               rsp_negative_error
);
   import sqrs_pkg::*;

   localparam int unsigned RW = DATA_WIDTH / 2;
   localparam int unsigned PW = 2 * RW;
   localparam int unsigned BW = $clog2(RW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT_MUL,
      ST_ROOT_CMP,
      ST_CAND_CHECK,
      ST_CAND_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [DATA_WIDTH-1:0] n_ff, n_in;
   logic [RW-1:0]         root_ff, root_in;
   logic [BW-1:0]         bit_ff, bit_in;
   logic [RW-1:0]         t_ff, t_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [COEF_WIDTH-1:0] res_coef_ff, res_coef_in;
   logic [REM_WIDTH-1:0]  res_rem_ff, res_rem_in;
   logic                  res_neg_ff, res_neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COEF_WIDTH-1:0] rsp_coef_ff, rsp_coef_in;
   logic [REM_WIDTH-1:0]  rsp_rem_ff, rsp_rem_in;
   logic                  rsp_neg_ff, rsp_neg_in;

   logic [RW-1:0]         trial;
   logic [RW-1:0]         mul_op;
   logic [PW-1:0]         product;
   logic                  out_free;
   logic                  div_start;
   logic [DATA_WIDTH-1:0] div_quo;
   logic [DATA_WIDTH-1:0] div_rem;
   div_status_type        div_st;
   logic [63:0]           t_wide;
   logic [63:0]           n_wide;
   logic [63:0]           quo_wide;

   // Next root candidate: the bits found so far plus the bit under test.
   assign trial = root_ff | (RW'(1) << bit_ff);

   // The shared squarer serves both the root search and the candidate divisors.
   assign mul_op  = (state_ff == ST_ROOT_MUL) ? trial : t_ff;
   assign product = PW'(mul_op) * PW'(mul_op);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign div_start = (state_ff == ST_DIV_START);

   assign t_wide   = 64'(t_ff);
   assign n_wide   = 64'(n_ff);
   assign quo_wide = 64'(div_quo);

   sqrs_divider #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (n_ff),
      .divisor   (DATA_WIDTH'(prod_ff)),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_st)
   );

   // Sequencer: root search, then downward candidate tests on the divider; a negative or zero radicand skips both.
   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      root_in     = root_ff;
      bit_in      = bit_ff;
      t_in        = t_ff;
      prod_in     = prod_ff;
      res_coef_in = res_coef_ff;
      res_rem_in  = res_rem_ff;
      res_neg_in  = res_neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in       = req_radicand;
               res_neg_in = req_radicand[DATA_WIDTH-1];
               root_in    = '0;
               bit_in     = BW'(RW - 1);
               if (req_radicand[DATA_WIDTH-1] || (req_radicand == '0)) begin
                  res_coef_in = '0;
                  res_rem_in  = REM_WIDTH'(1);
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_ROOT_MUL;
               end
            end
         end
         ST_ROOT_MUL: begin
            prod_in  = product;
            state_in = ST_ROOT_CMP;
         end
         ST_ROOT_CMP: begin
            if (DATA_WIDTH'(prod_ff) <= n_ff) begin
               root_in = trial;
            end
            if (bit_ff == '0) begin
               t_in     = (DATA_WIDTH'(prod_ff) <= n_ff) ? trial : root_ff;
               state_in = ST_CAND_CHECK;
            end else begin
               bit_in   = bit_ff - BW'(1);
               state_in = ST_ROOT_MUL;
            end
         end
         ST_CAND_CHECK: begin
            if (t_ff <= RW'(1)) begin
               // No square above one divides the radicand.
               res_coef_in = COEF_WIDTH'(1);
               res_rem_in  = n_wide[REM_WIDTH-1:0];
               state_in    = ST_DONE;
            end else begin
               state_in = ST_CAND_MUL;
            end
         end
         ST_CAND_MUL: begin
            prod_in  = product;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_st.done) begin
               if (div_rem == '0) begin
                  res_coef_in = t_wide[COEF_WIDTH-1:0];
                  res_rem_in  = quo_wide[REM_WIDTH-1:0];
                  state_in    = ST_DONE;
               end else begin
                  t_in     = t_ff - RW'(1);
                  state_in = ST_CAND_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loaded from the finished request once the slot is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_coef_in  = rsp_coef_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_neg_in   = rsp_neg_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_coef_in  = res_coef_ff;
         rsp_rem_in   = res_rem_ff;
         rsp_neg_in   = res_neg_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      t_ff        <= t_in;
      prod_ff     <= prod_in;
      res_coef_ff <= res_coef_in;
      res_rem_ff  <= res_rem_in;
      res_neg_ff  <= res_neg_in;
      rsp_coef_ff <= rsp_coef_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_neg_ff  <= rsp_neg_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_coefficient    = rsp_coef_ff;
   assign rsp_remainder      = rsp_rem_ff;
   assign rsp_negative_error = rsp_neg_ff;

   // A negative radicand always reports the fixed error result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_negative_error) |-> (rsp_coefficient == '0 && rsp_remainder == 1))
      else $error("negative radicand gave a result other than a=0, b=1");

   // A zero coefficient only ever comes with a remainder of one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_coefficient == '0) |-> (rsp_remainder == 1))
      else $error("zero coefficient with a remainder other than one");

   // Only candidates of two or more reach the divider.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CAND_MUL || state_ff == ST_DIV_START || state_ff == ST_DIV_WAIT)
      |-> (t_ff > RW'(1)))
      else $error("candidate below two sent to the divider");

   // The divider is never left running while the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_st.busy)
      else $error("divider busy while the sequencer is idle");

endmodule
